@@ design/uarb_pkg.sv @@
// Package: shared types and codes for the UART register bridge.
`timescale 1ns / 1ps

package uarb_pkg;

  // Event kinds on the input channel
  localparam logic [1:0] CMD_RX     = 2'd0;
  localparam logic [1:0] CMD_TXDONE = 2'd1;
  localparam logic [1:0] CMD_IRQ    = 2'd2;

  // Top two bits of a received command byte
  localparam logic [1:0] OP_WRITE = 2'b10;
  localparam logic [1:0] OP_READ  = 2'b01;

  // Bytes sent back over the link
  localparam logic [7:0] ECHO_WRITE = 8'h80;
  localparam logic [7:0] ECHO_READ  = 8'h40;
  localparam logic [7:0] NOTICE     = 8'h00;

  localparam int IDX_W         = 5;
  localparam int DEF_REG_COUNT = 32;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } store_wr_t;

endpackage

@@ design/uarb_channels.sv @@
// Interfaces: input event channel and output byte channel.
`timescale 1ns / 1ps

interface uarb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface uarb_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;

  modport source (output valid, output tx_valid, output tx_byte, input ready);
  modport sink   (input valid, input tx_valid, input tx_byte, output ready);
endinterface

@@ design/uart_register_bridge_top.sv @@
// UART register bridge: command decode, transmit queueing and result register.
// Usage:
//   in_ch carries one event per transaction: cmd 0 is a received byte (rx_byte),
//   cmd 1 is transmit done, cmd 2 is an external interrupt; cmd 3 does nothing.
//   out_ch carries exactly one result per input transaction: tx_valid says a
//   byte (tx_byte) goes to the transmitter now; tx_byte is 0 when it does not.
//   Byte 10xaaaaa arms a write to register aaaaa, the next byte is stored and
//   0x80 echoed. Byte 01xaaaaa echoes 0x40, then the register follows on a
//   later transmit done. Echo beats read data beats the 0x00 interrupt notice.
// Result: registered, on out_ch in the cycle after the input transaction.
// Throughput: one transaction per cycle unless out_ch stalls; the decode and the
//   flag updates are a single pass of logic, and the store read data is kept
//   registered for the current index, so a new event is taken every cycle then.
// Stall: the result register holds while out_ch.ready is low; in_ch.ready
//   stays high as long as the result register is empty or being drained.
// Reset: synchronous; all flags clear, the transmitter is idle and every
//   store entry reads as zero at once (per-entry valid bits, no clear pass).
`timescale 1ns / 1ps

module uart_register_bridge_top #(
  parameter int REG_COUNT = uarb_pkg::DEF_REG_COUNT
) (
  input logic        clk,
  input logic        rst,
  uarb_in_if.sink    in_ch,
  uarb_out_if.source out_ch
);

  logic                       fire;
  logic [uarb_pkg::IDX_W-1:0] reg_index, reg_index_next;
  logic                       write_armed, write_armed_next;
  logic                       read_pending, read_pending_next;
  logic                       echo_pending, echo_pending_next;
  logic [7:0]                 echo_value, echo_value_next;
  logic                       notice_pending, notice_pending_next;
  logic                       tx_idle, tx_idle_next;
  logic                       o_valid;
  logic                       o_tx_valid, o_tx_valid_next;
  logic [7:0]                 o_tx_byte, o_tx_byte_next;
  logic                       echo_now;
  logic [7:0]                 echo_byte;
  logic [7:0]                 rd_data;
  logic                       rd_ok;
  uarb_pkg::store_wr_t        wr;

  assign in_ch.ready     = !o_valid || out_ch.ready;
  assign fire            = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = o_valid;
  assign out_ch.tx_valid = o_tx_valid;
  assign out_ch.tx_byte  = o_tx_byte;

  uarb_store #(
    .REG_COUNT (REG_COUNT)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .rd_idx_next (reg_index_next),
    .rd_data     (rd_data),
    .rd_ok       (rd_ok)
  );

  always_comb begin
    reg_index_next      = reg_index;
    write_armed_next    = write_armed;
    read_pending_next   = read_pending;
    echo_pending_next   = echo_pending;
    echo_value_next     = echo_value;
    notice_pending_next = notice_pending;
    tx_idle_next        = tx_idle;
    o_tx_valid_next     = 1'b0;
    o_tx_byte_next      = 8'h00;
    echo_now            = 1'b0;
    echo_byte           = uarb_pkg::ECHO_WRITE;
    wr.en               = 1'b0;
    wr.idx              = reg_index;
    wr.data             = in_ch.rx_byte;

    if (fire) begin
      case (in_ch.cmd)
        uarb_pkg::CMD_RX: begin
          if (write_armed) begin
            wr.en            = 1'b1;
            write_armed_next = 1'b0;
            echo_now         = 1'b1;
            echo_byte        = uarb_pkg::ECHO_WRITE;
          end else if (in_ch.rx_byte[7:6] == uarb_pkg::OP_WRITE) begin
            reg_index_next   = in_ch.rx_byte[uarb_pkg::IDX_W-1:0];
            write_armed_next = 1'b1;
          end else if (in_ch.rx_byte[7:6] == uarb_pkg::OP_READ) begin
            reg_index_next    = in_ch.rx_byte[uarb_pkg::IDX_W-1:0];
            read_pending_next = 1'b1;
            echo_now          = 1'b1;
            echo_byte         = uarb_pkg::ECHO_READ;
          end
        end
        uarb_pkg::CMD_TXDONE: begin
          if (echo_pending) begin
            echo_pending_next = 1'b0;
            o_tx_valid_next   = 1'b1;
            o_tx_byte_next    = echo_value;
          end else if (read_pending) begin
            read_pending_next = 1'b0;
            o_tx_valid_next   = 1'b1;
            o_tx_byte_next    = rd_ok ? rd_data : 8'h00;
          end else if (notice_pending) begin
            notice_pending_next = 1'b0;
            o_tx_valid_next     = 1'b1;
            o_tx_byte_next      = uarb_pkg::NOTICE;
          end else begin
            tx_idle_next = 1'b1;
          end
        end
        uarb_pkg::CMD_IRQ: begin
          if (!notice_pending) begin
            if (tx_idle) begin
              tx_idle_next    = 1'b0;
              o_tx_valid_next = 1'b1;
              o_tx_byte_next  = uarb_pkg::NOTICE;
            end else begin
              notice_pending_next = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase

      // echo goes out now if the transmitter is idle, else it waits
      if (echo_now) begin
        if (tx_idle) begin
          tx_idle_next    = 1'b0;
          o_tx_valid_next = 1'b1;
          o_tx_byte_next  = echo_byte;
        end else begin
          echo_pending_next = 1'b1;
          echo_value_next   = echo_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_index      <= '0;
      write_armed    <= 1'b0;
      read_pending   <= 1'b0;
      echo_pending   <= 1'b0;
      echo_value     <= 8'h00;
      notice_pending <= 1'b0;
      tx_idle        <= 1'b1;
      o_valid        <= 1'b0;
    end else begin
      reg_index      <= reg_index_next;
      write_armed    <= write_armed_next;
      read_pending   <= read_pending_next;
      echo_pending   <= echo_pending_next;
      echo_value     <= echo_value_next;
      notice_pending <= notice_pending_next;
      tx_idle        <= tx_idle_next;
      if (fire) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_tx_valid <= o_tx_valid_next;
      o_tx_byte  <= o_tx_byte_next;
    end
  end

  // anything queued means the transmitter is busy
  a_queue_busy: assert property (@(posedge clk) disable iff (rst)
    (echo_pending || read_pending || notice_pending) |-> !tx_idle)
    else $error("queued byte while transmitter idle");

  a_echo_first: assert property (@(posedge clk) disable iff (rst)
    (fire && in_ch.cmd == uarb_pkg::CMD_TXDONE && echo_pending)
    |=> (!echo_pending && o_valid && o_tx_valid && o_tx_byte == $past(echo_value)))
    else $error("queued echo not sent first on transmit done");

  a_idle_on_done: assert property (@(posedge clk) disable iff (rst)
    $rose(tx_idle) |-> $past(fire && in_ch.cmd == uarb_pkg::CMD_TXDONE))
    else $error("transmitter marked idle without transmit done");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    fire |=> o_valid)
    else $error("accepted transaction left no result");

endmodule

@@ design/uarb_store.sv @@
// Register store: cleared at reset by valid bits, one write and one registered read.
`timescale 1ns / 1ps

module uarb_store #(
  parameter int REG_COUNT = uarb_pkg::DEF_REG_COUNT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  uarb_pkg::store_wr_t       wr,
  input  logic [uarb_pkg::IDX_W-1:0] rd_idx_next,
  output logic [7:0]                rd_data,
  output logic                      rd_ok
);

  localparam int ADDR_W = $clog2(REG_COUNT);

  logic [7:0]                      mem [REG_COUNT];
  logic [REG_COUNT-1:0]            valid;
  logic [ADDR_W+uarb_pkg::IDX_W-1:0] wr_ext;
  logic [ADDR_W+uarb_pkg::IDX_W-1:0] rd_ext;
  logic [ADDR_W-1:0]               wr_addr;
  logic [ADDR_W-1:0]               rd_addr;
  logic                            wr_in_range;
  logic                            rd_in_range;
  logic                            wr_hit;

  assign wr_ext      = {{ADDR_W{1'b0}}, wr.idx};
  assign rd_ext      = {{ADDR_W{1'b0}}, rd_idx_next};
  assign wr_addr     = wr_ext[ADDR_W-1:0];
  assign rd_addr     = rd_ext[ADDR_W-1:0];
  assign wr_in_range = 32'(wr.idx) < REG_COUNT;
  assign rd_in_range = 32'(rd_idx_next) < REG_COUNT;
  // writes past the end of the store are dropped
  assign wr_hit      = wr.en && wr_in_range;

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_addr] <= wr.data;
    end
    // bypass a write to the entry being read
    if (wr_hit && wr.idx == rd_idx_next) begin
      rd_data <= wr.data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr_hit) begin
        valid[wr_addr] <= 1'b1;
      end
      if (wr_hit && wr.idx == rd_idx_next) begin
        rd_ok <= 1'b1;
      end else begin
        rd_ok <= rd_in_range && valid[rd_addr];
      end
    end
  end

endmodule

@@ tb/sv/uart_register_bridge_top_test.sv @@
// Testbench for the UART register bridge: random handshakes, scoreboard check of every result.
`timescale 1ns / 1ps

class bridge_scoreboard #(int NREG = 32);
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
  } tx_result_t;

  logic [7:0]                 regs [NREG];
  logic [uarb_pkg::IDX_W-1:0] index;
  bit                         armed;
  bit                         read_wait;
  bit                         echo_wait;
  bit                         notice_wait;
  bit                         tx_free;
  logic [7:0]                 echo_byte;
  tx_result_t                 due_q [$];
  int                         fail_count;

  function new();
    foreach (regs[i]) regs[i] = '0;
    index       = '0;
    armed       = 1'b0;
    read_wait   = 1'b0;
    echo_wait   = 1'b0;
    notice_wait = 1'b0;
    tx_free     = 1'b1;
    echo_byte   = '0;
    fail_count  = 0;
  endfunction

  function void flag(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // Hand an echo to the transmitter if it is free, else park it (newest wins).
  function void send_echo(logic [7:0] v, inout tx_result_t r);
    if (tx_free) begin
      tx_free = 1'b0;
      r = '{1'b1, v};
    end else begin
      echo_wait = 1'b1;
      echo_byte = v;
    end
  endfunction

  function void note_event(logic [1:0] cmd, logic [7:0] b);
    tx_result_t r;
    r = '0;
    case (cmd)
      uarb_pkg::CMD_RX: begin
        if (armed) begin
          if (int'(index) < NREG) regs[index] = b;
          armed = 1'b0;
          send_echo(uarb_pkg::ECHO_WRITE, r);
        end else if (b[7:6] == uarb_pkg::OP_WRITE) begin
          index = b[uarb_pkg::IDX_W-1:0];
          armed = 1'b1;
        end else if (b[7:6] == uarb_pkg::OP_READ) begin
          index     = b[uarb_pkg::IDX_W-1:0];
          read_wait = 1'b1;
          send_echo(uarb_pkg::ECHO_READ, r);
        end
      end
      uarb_pkg::CMD_TXDONE: begin
        if (echo_wait) begin
          echo_wait = 1'b0;
          r = '{1'b1, echo_byte};
        end else if (read_wait) begin
          read_wait = 1'b0;
          r = '{1'b1, (int'(index) < NREG) ? regs[index] : 8'h00};
        end else if (notice_wait) begin
          notice_wait = 1'b0;
          r = '{1'b1, uarb_pkg::NOTICE};
        end else begin
          tx_free = 1'b1;
        end
      end
      uarb_pkg::CMD_IRQ: begin
        if (!notice_wait) begin
          if (tx_free) begin
            tx_free = 1'b0;
            r = '{1'b1, uarb_pkg::NOTICE};
          end else begin
            notice_wait = 1'b1;
          end
        end
      end
      default: ;
    endcase
    due_q.push_back(r);
  endfunction

  function void check_result(logic v, logic [7:0] b);
    tx_result_t exp;
    if (due_q.size() == 0) begin
      flag($sformatf("unexpected result: tx_valid=%b tx_byte=%02h", v, b));
      return;
    end
    exp = due_q.pop_front();
    if (v !== exp.tx_valid || b !== exp.tx_byte)
      flag($sformatf("mismatch: tx_valid exp %b got %b, tx_byte exp %02h got %02h",
                     exp.tx_valid, v, exp.tx_byte, b));
  endfunction

  function void finish_check();
    if (due_q.size() != 0)
      flag($sformatf("%0d results never arrived", due_q.size()));
  endfunction
endclass

module uart_register_bridge_top_test;
  localparam int REG_COUNT = uarb_pkg::DEF_REG_COUNT;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1100;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk;
  logic rst;
  bit   calm;
  int   quiet_cycles;
  int   items;
  int   pick;

  bridge_scoreboard #(REG_COUNT) sb;

  uarb_in_if  in_ch ();
  uarb_out_if out_ch ();

  uart_register_bridge_top #(
    .REG_COUNT(REG_COUNT)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sink side: random back-pressure outside the calm stretch.
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 17);
  end

  // Monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) sb.note_event(in_ch.cmd, in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.tx_valid, out_ch.tx_byte);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Valid is only dropped when an idle gap follows, so it never toggles within a step.
  task automatic send_event(input logic [1:0] c, input logic [7:0] b);
    if (!calm && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 17);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= c;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_write(input logic [7:0] addr_byte, input logic [7:0] data);
    send_event(uarb_pkg::CMD_RX, addr_byte);
    send_event(uarb_pkg::CMD_RX, data);
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    rst <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.cmd     <= uarb_pkg::CMD_RX;
    in_ch.rx_byte <= 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // interrupt notice: at once when idle, queued when busy, no duplicate
    send_event(uarb_pkg::CMD_IRQ, 8'hFF);
    send_event(uarb_pkg::CMD_IRQ, 8'h00);
    send_event(uarb_pkg::CMD_IRQ, 8'h00);
    send_event(uarb_pkg::CMD_TXDONE, 8'h00);
    send_event(uarb_pkg::CMD_TXDONE, 8'h00);
    send_event(uarb_pkg::CMD_TXDONE, 8'hFF);   // done while already idle
    send_write(8'h80, 8'hFF);                  // reg 0, echo goes out at once
    send_write(8'hBF, 8'hA5);                  // bit 5 ignored -> reg 31, echo queued
    send_event(uarb_pkg::CMD_RX, 8'h5F);       // read echo replaces queued write echo
    send_event(uarb_pkg::CMD_RX, 8'h60);       // second read retargets index to reg 0
    send_event(uarb_pkg::CMD_IRQ, 8'h00);
    repeat (4) send_event(uarb_pkg::CMD_TXDONE, 8'h00);
    send_event(uarb_pkg::CMD_RX, 8'h00);       // ignored command bytes
    send_event(uarb_pkg::CMD_RX, 8'hFF);
    send_event(uarb_pkg::CMD_RX, 8'h3F);
    send_event(CMD_UNUSED, 8'hFF);
    send_write(8'h9F, 8'h00);
    send_event(uarb_pkg::CMD_RX, 8'h7F);
    repeat (3) send_event(uarb_pkg::CMD_TXDONE, 8'h00);

    items = 0;
    while (items < RANDOM_ITEMS) begin
      calm = (items >= 400 && items < 700);
      pick = $urandom_range(99);
      if (pick < 25) begin
        send_write({uarb_pkg::OP_WRITE, 1'($urandom), 5'($urandom)}, 8'($urandom));
        items += 2;
      end else if (pick < 45) begin
        send_event(uarb_pkg::CMD_RX, {uarb_pkg::OP_READ, 1'($urandom), 5'($urandom)});
        items++;
      end else if (pick < 80) begin
        send_event(uarb_pkg::CMD_TXDONE, 8'($urandom));
        items++;
      end else if (pick < 88) begin
        send_event(uarb_pkg::CMD_IRQ, 8'($urandom));
        items++;
      end else begin
        // noise: any kind, any byte; may break a write in progress
        send_event(2'($urandom), 8'($urandom));
        items++;
      end
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    sb.finish_check();
    if (sb.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

@@ sim.f @@
design/uarb_pkg.sv
design/uarb_channels.sv
design/uarb_store.sv
design/uart_register_bridge_top.sv
tb/sv/uart_register_bridge_top_test.sv
